// File: rtl/arw_pkg.sv
// Shared types and codes for the anti-replay window block.
`default_nettype none

package arw_pkg;

   // Operation codes carried by an input item
   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_MARK  = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_SPAN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_SPAN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CENTER = 2'd2;

   // Field widths
   localparam int unsigned ID_W    = 32;
   localparam int unsigned BELOW_W = 7;
   localparam int unsigned ABOVE_W = 8;
   localparam int unsigned CSR_W   = 32;

   // Reset value of the lower span
   localparam logic [BELOW_W-1:0] BELOW_RESET = 7'd127;

   // Input item
   typedef struct packed {
      logic            op;
      logic [ID_W-1:0] id;
   } req_type;

   // Result item
   typedef struct packed {
      logic            answer;
      logic [ID_W-1:0] center_now;
   } rsp_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic clear;   // drop the flag
      logic shift;   // take the neighbour's flag (or zero past the window top)
      logic keep;    // neighbour lies inside the window
      logic set;     // raise the flag
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: rtl/arw_cell.sv
// One flag cell of the window bitmap; shifts down from its upper neighbour.
`default_nettype none

module arw_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire arw_pkg::cell_ctl_type ctl,
   input  wire logic                  upper_flag,
   output logic                       flag
);

   logic flag_ff;
   logic flag_in;

   // Clear wins, then shift, then set
   always_comb begin
      flag_in = flag_ff;
      if (ctl.clear) begin
         flag_in = 1'b0;
      end else if (ctl.shift) begin
         flag_in = ctl.keep ? upper_flag : 1'b0;
      end else if (ctl.set) begin
         flag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   assign flag = flag_ff;

endmodule

`default_nettype wire

// File: rtl/anti_replay_window.sv
// Top level of the sliding-window anti-replay block.
`default_nettype none

// Sliding-window anti-replay filter. It keeps a 32-bit center ID and a row of
// MAX_FLAG_BYTES*8 flag cells, flag k standing for ID center-(fb-k), where fb is
// the lower span capped at the cell count less one. A query (op 0) answers whether
// an ID at or below the center is inside the window and already flagged; a mark
// (op 1) accepts IDs in [center-fb, center+upper span], bounds wrapping modulo
// 2^32, and flags them. A mark above the center moves the bitmap down by the
// increment, one position per cycle through the cell row. Queries, rejected
// marks and marks at or below the center go from evaluation to the result; a
// forward mark with inc <= fb shifts and then sets the top flag, and a forward
// jump past the whole bitmap clears it at once and then sets the top flag. One
// item is in work at a time; the next may be accepted while a result waits to
// be taken. Writing start_center reloads the center and clears every flag.
module anti_replay_window #(
   parameter int MAX_FLAG_BYTES = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire arw_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output arw_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_write,
   input  wire logic [arw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [arw_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int NF  = MAX_FLAG_BYTES * 8;
   localparam int FBW = $clog2(NF);
   localparam int CAP = NF - 1;
   localparam int IDW = arw_pkg::ID_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_SETTOP = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]                     state_ff, state_in;
   arw_pkg::req_type               req_ff, req_in;
   logic [IDW-1:0]                 center_ff, center_in;
   logic [FBW-1:0]                 cnt_ff, cnt_in;
   logic                           ans_ff, ans_in;
   arw_pkg::rsp_type               rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [arw_pkg::BELOW_W-1:0]    below_ff, below_in;
   logic [arw_pkg::ABOVE_W-1:0]    above_ff, above_in;

   logic [FBW-1:0]                 fb;
   logic [7:0]                     below_wide;
   logic [IDW-1:0]                 lo, hi, gap_down, inc;
   logic                           in_win, at_or_below, big_jump;
   logic [FBW-1:0]                 idx;
   logic [NF-1:0]                  flags;
   logic                           set_en, shift_en, clear_all;
   logic [FBW-1:0]                 set_idx;
   logic                           csr_center_wr;

   // Effective window depth
   assign below_wide = {1'b0, below_ff};
   assign fb = (below_wide > 8'(CAP)) ? FBW'(CAP) : FBW'(below_wide);

   // Window evaluation on the held item
   assign lo          = center_ff - IDW'(fb);
   assign hi          = center_ff + IDW'(above_ff);
   assign in_win      = (req_ff.id >= lo) && (req_ff.id <= hi);
   assign at_or_below = req_ff.id <= center_ff;
   assign gap_down    = center_ff - req_ff.id;
   assign inc         = req_ff.id - center_ff;
   assign big_jump    = inc > IDW'(fb);
   assign idx         = fb - gap_down[FBW-1:0];

   assign csr_center_wr = csr_write && (csr_index == arw_pkg::CSR_START_CENTER);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      center_in    = center_ff;
      cnt_in       = cnt_ff;
      ans_in       = ans_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      below_in     = below_ff;
      above_in     = above_ff;
      set_en       = 1'b0;
      set_idx      = fb;
      shift_en     = 1'b0;
      clear_all    = csr_center_wr;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_DONE;
            if (req_ff.op == arw_pkg::OP_QUERY) begin
               ans_in = at_or_below && in_win && flags[idx];
            end else if (!in_win) begin
               ans_in = 1'b0;
            end else if (at_or_below) begin
               ans_in  = 1'b1;
               set_en  = 1'b1;
               set_idx = idx;
            end else begin
               ans_in    = 1'b1;
               center_in = req_ff.id;
               if (big_jump) begin
                  clear_all = 1'b1;
                  state_in  = S_SETTOP;
               end else begin
                  cnt_in   = inc[FBW-1:0] - FBW'(1);
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            shift_en = 1'b1;
            cnt_in   = cnt_ff - FBW'(1);
            if (cnt_ff == '0) begin
               state_in = S_SETTOP;
            end
         end
         S_SETTOP: begin
            set_en   = 1'b1;
            set_idx  = fb;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.answer     = ans_ff;
               rsp_in.center_now = center_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Configuration writes
      if (csr_write) begin
         unique case (csr_index)
            arw_pkg::CSR_LOW_SPAN:     below_in  = csr_wdata[arw_pkg::BELOW_W-1:0];
            arw_pkg::CSR_HIGH_SPAN:    above_in  = csr_wdata[arw_pkg::ABOVE_W-1:0];
            arw_pkg::CSR_START_CENTER: center_in = csr_wdata[IDW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         center_ff    <= '0;
         below_ff     <= arw_pkg::BELOW_RESET;
         above_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         center_ff    <= center_in;
         below_ff     <= below_in;
         above_ff     <= above_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      cnt_ff <= cnt_in;
      ans_ff <= ans_in;
      rsp_ff <= rsp_in;
   end

   // Row of flag cells, each shifting down from its upper neighbour
   for (genvar k = 0; k < NF; k++) begin : g_cell
      arw_pkg::cell_ctl_type ctl;
      logic                  upper;

      assign ctl.clear = clear_all;
      assign ctl.shift = shift_en;
      assign ctl.keep  = (FBW+1)'(k + 1) <= {1'b0, fb};
      assign ctl.set   = set_en && (set_idx == FBW'(k));

      if (k == NF - 1) begin : g_top
         assign upper = 1'b0;
      end else begin : g_mid
         assign upper = flags[k+1];
      end

      arw_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .upper_flag (upper),
         .flag       (flags[k])
      );
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for the anti-replay window: edge-case table, then a random walk around the window.
module tb;

   localparam int FLAG_N       = 16 * 8;      // flag cells at the default MAX_FLAG_BYTES
   localparam int IDW          = arw_pkg::ID_W;
   localparam int CSR_N        = arw_pkg::CSR_W;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int SEG_ITEMS    = 150;
   localparam int LONG_HOLD    = 300;

   // Short names for the codes used in the table
   localparam logic OPQ = arw_pkg::OP_QUERY;
   localparam logic OPM = arw_pkg::OP_MARK;
   localparam logic [arw_pkg::CSR_IDX_W-1:0] RG_LOW   = arw_pkg::CSR_LOW_SPAN;
   localparam logic [arw_pkg::CSR_IDX_W-1:0] RG_HIGH  = arw_pkg::CSR_HIGH_SPAN;
   localparam logic [arw_pkg::CSR_IDX_W-1:0] RG_START = arw_pkg::CSR_START_CENTER;

   typedef enum logic {STEP_ITEM, STEP_CSR} step_kind_type;

   // One row of the edge-case table; the unused fields of a row are fillers
   typedef struct packed {
      step_kind_type                 kind;
      logic                          op;
      logic [arw_pkg::CSR_IDX_W-1:0] csr_idx;
      logic [IDW-1:0]                value;        // ID of an item, or register data
      logic                          typed;        // check against the values below
      logic                          want_answer;
      logic [IDW-1:0]                want_center;
   } step_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   arw_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   arw_pkg::rsp_type                rsp_data;
   logic                            csr_write = 1'b0;
   logic [arw_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_N-1:0]                csr_wdata = '0;

   // Own copy of the window state and registers
   logic [IDW-1:0]                  win_center = '0;
   logic [FLAG_N-1:0]               win_flags = '0;
   logic [arw_pkg::BELOW_W-1:0]     win_below = arw_pkg::BELOW_RESET;
   logic [arw_pkg::ABOVE_W-1:0]     win_above = '0;

   arw_pkg::rsp_type                window_results[$];
   step_type                        plan[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_request = 0;
   int stall_left    = 0;
   int n_errors      = 0;
   int n_results     = 0;
   int n_queries     = 0;
   int n_marks       = 0;
   int n_accepted    = 0;
   int n_forward     = 0;
   int n_settings    = 0;

   anti_replay_window u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #(LIMIT_CYCLES * 4);
      $display("Timeout: %0d results still pending", window_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      n_errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // Predict one item and advance the window copy.
   // The lower span is 7 bits wide, so it never exceeds the cell count less one.
   function automatic arw_pkg::rsp_type window_step(input arw_pkg::req_type item);
      logic [IDW-1:0]    lo, hi, gap, inc;
      logic [FLAG_N-1:0] keep_mask;
      logic              in_win;
      arw_pkg::rsp_type  res;
      lo     = win_center - IDW'(win_below);
      hi     = win_center + IDW'(win_above);
      in_win = (item.id >= lo) && (item.id <= hi);
      gap    = win_center - item.id;
      res.answer = 1'b0;
      if (item.op == arw_pkg::OP_QUERY) begin
         n_queries++;
         if (item.id <= win_center && in_win) res.answer = win_flags[IDW'(win_below) - gap];
      end else begin
         n_marks++;
         if (in_win) begin
            n_accepted++;
            res.answer = 1'b1;
            if (item.id <= win_center) begin
               win_flags[IDW'(win_below) - gap] = 1'b1;
            end else begin
               // forward move: cells above the window drop out, the rest slide down
               n_forward++;
               inc       = item.id - win_center;
               keep_mask = {FLAG_N{1'b1}} >> (FLAG_N - 1 - int'(win_below));
               if (inc <= IDW'(win_below)) win_flags = (win_flags & keep_mask) >> inc;
               else win_flags = '0;
               win_center           = item.id;
               win_flags[win_below] = 1'b1;
            end
         end
      end
      res.center_now = win_center;
      return res;
   endfunction

   // Offer one item, idling at random first; valid stays up after acceptance
   task automatic offer_item(input arw_pkg::req_type item, input logic typed,
                             input arw_pkg::rsp_type typed_rsp);
      arw_pkg::rsp_type got;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      got = window_step(item);
      window_results.push_back(typed ? typed_rsp : got);
   endtask

   // Stop offering and let every pending result come back
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (window_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write, only once the block has gone idle
   task automatic csr_put(input logic [arw_pkg::CSR_IDX_W-1:0] idx,
                          input logic [CSR_N-1:0] value);
      hold_until_drained();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         RG_LOW:  win_below = value[arw_pkg::BELOW_W-1:0];
         RG_HIGH: win_above = value[arw_pkg::ABOVE_W-1:0];
         RG_START: begin
            win_center = value;
            win_flags  = '0;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Receiver: random back-pressure, plus a long hold when asked
   always @(negedge clock) begin
      if (stall_request != 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Compare each result with the oldest prediction
   always @(posedge clock) begin
      arw_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (window_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result answer=%0b center=%h",
                                      rsp_data.answer, rsp_data.center_now));
         end else begin
            want = window_results.pop_front();
            if (rsp_data.answer !== want.answer)
               report_mismatch($sformatf("answer %0b, wanted %0b", rsp_data.answer, want.answer));
            if (rsp_data.center_now !== want.center_now)
               report_mismatch($sformatf("center_now %h, wanted %h",
                                         rsp_data.center_now, want.center_now));
         end
      end
   end

   initial begin
      arw_pkg::req_type             item;
      arw_pkg::rsp_type             typed_rsp;
      logic [arw_pkg::BELOW_W-1:0]  below_v;
      logic [arw_pkg::ABOVE_W-1:0]  above_v;
      logic [IDW-1:0]               start_v;
      int                           pick;

      // Edge cases: wrapped windows, bounds, shifts, clears, register changes
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'd0, 1'b1, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd0, 1'b1, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'd1, 1'b1, 1'b0, 32'd0});
      plan.push_back('{STEP_CSR, OPQ, RG_HIGH, 32'd255, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_CSR, OPQ, RG_START, 32'd1000, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd1000, 1'b1, 1'b1, 32'd1000});
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'd1000, 1'b1, 1'b1, 32'd1000});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd872, 1'b1, 1'b0, 32'd1000});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd873, 1'b1, 1'b1, 32'd1000});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd1255, 1'b1, 1'b1, 32'd1255});
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'd1000, 1'b1, 1'b0, 32'd1255});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd1256, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd1300, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'd1255, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'd1301, 1'b1, 1'b0, 32'd1300});
      plan.push_back('{STEP_CSR, OPQ, RG_LOW, 32'd7, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd1307, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'd1300, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd1299, 1'b1, 1'b0, 32'd1307});
      // widening the window again exposes stale flags
      plan.push_back('{STEP_CSR, OPQ, RG_LOW, 32'd127, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'd1187, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'd1307, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_CSR, OPQ, RG_LOW, 32'd100, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd1250, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd1562, 1'b0, 1'b0, 32'd0});
      // top of the ID range: the upper bound wraps and the window empties
      plan.push_back('{STEP_CSR, OPQ, RG_START, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'd5, 1'b1, 1'b0, 32'hFFFF_FFFF});
      plan.push_back('{STEP_CSR, OPQ, RG_HIGH, 32'd0, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'hFFFF_FF9B, 1'b1, 1'b1, 32'hFFFF_FFFF});
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'hFFFF_FF9B, 1'b1, 1'b1, 32'hFFFF_FFFF});
      plan.push_back('{STEP_CSR, OPQ, RG_LOW, 32'd0, 1'b0, 1'b0, 32'd0});
      plan.push_back('{STEP_ITEM, OPM, RG_LOW, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF});
      plan.push_back('{STEP_ITEM, OPQ, RG_LOW, 32'hFFFF_FFFE, 1'b1, 1'b0, 32'hFFFF_FFFF});

      // Synchronous reset
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 51;
      foreach (plan[i]) begin
         if (plan[i].kind == STEP_CSR) begin
            csr_put(plan[i].csr_idx, plan[i].value);
         end else begin
            item.op              = plan[i].op;
            item.id              = plan[i].value;
            typed_rsp.answer     = plan[i].want_answer;
            typed_rsp.center_now = plan[i].want_center;
            offer_item(item, plan[i].typed, typed_rsp);
         end
      end

      // Random walk: three idling mixes, three window settings each
      for (int seg = 0; seg < 9; seg++) begin
         case (seg / 3)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 51;
            end
            1: begin
               send_idle_pct = 51;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (seg % 4)
            0: begin
               below_v = 7'd127;
               above_v = 8'd128;
               start_v = $urandom;
            end
            1: begin
               below_v = 7'd7;
               above_v = 8'd255;
               start_v = 32'hFFFF_FFF0 | $urandom_range(0, 15);
            end
            2: begin
               below_v = 7'($urandom_range(0, 127));
               above_v = 8'($urandom_range(0, 255));
               start_v = $urandom_range(0, 60);
            end
            default: begin
               below_v = 7'($urandom_range(0, 15));
               above_v = 8'($urandom_range(0, 3));
               start_v = $urandom;
            end
         endcase
         // spare upper data bits carry noise; the block should ignore them
         csr_put(RG_LOW, ($urandom & ~32'h7F) | CSR_N'(below_v));
         csr_put(RG_HIGH, ($urandom & ~32'hFF) | CSR_N'(above_v));
         csr_put(RG_START, start_v);
         n_settings++;

         // receiver holds off while items keep coming, so the input backs up
         if (seg == 6) stall_request = LONG_HOLD;

         for (int i = 0; i < SEG_ITEMS; i++) begin
            if (seg == 4 && i == SEG_ITEMS / 2) hold_until_drained();
            item.op = ($urandom_range(0, 99) < 60) ? arw_pkg::OP_MARK : arw_pkg::OP_QUERY;
            pick    = $urandom_range(0, 99);
            if (pick < 60) begin
               // around the window, a few IDs past each bound
               item.id = win_center - IDW'(win_below) - 32'd3
                         + IDW'($urandom_range(0, int'(win_below) + int'(win_above) + 6));
            end else if (pick < 70) begin
               case ($urandom_range(0, 2))
                  0: item.id = win_center - IDW'(win_below);
                  1: item.id = win_center;
                  default: item.id = win_center + IDW'(win_above);
               endcase
            end else if (pick < 85) begin
               item.id = win_center + IDW'($urandom_range(1, 4));
            end else begin
               item.id = $urandom;
            end
            offer_item(item, 1'b0, '0);
         end
      end

      hold_until_drained();
      repeat (20) @(posedge clock);

      $display("Run: %0d queries, %0d marks (%0d accepted, %0d forward moves), %0d results",
               n_queries, n_marks, n_accepted, n_forward, n_results);
      $display("Run: edge-case table plus %0d random window settings, %0d mismatches",
               n_settings, n_errors);
      if (n_errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
